// ----- hw/rtl/backup_container_parser_defines.svh -----
// assertion macros for the backup container parser
`ifndef BACKUP_CONTAINER_PARSER_DEFINES_SVH
`define BACKUP_CONTAINER_PARSER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BCP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define BCP_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ----- hw/rtl/bcp_pkg.sv -----
// types and constants for the backup container parser
`timescale 1ns / 1ps
package bcp_pkg;
   typedef enum logic [3:0] {
      SEC_MAGIC = 4'd0, SEC_VERSION = 4'd1, SEC_PATH_COUNT = 4'd2, SEC_CHILD_COUNT = 4'd3,
      SEC_CHILD_BYTE = 4'd4, SEC_SECRET_COUNT = 4'd5, SEC_SECRET_BYTE = 4'd6,
      SEC_ALGORITHM = 4'd7, SEC_NONCE = 4'd8, SEC_LENGTH = 4'd9, SEC_CIPHER = 4'd10,
      SEC_IGNORED = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_TRUNCATED = 3'd1, ST_BAD_MAGIC = 3'd2, ST_BAD_VERSION = 3'd3,
      ST_ZERO_CHILD = 3'd4, ST_ZERO_SECRET = 3'd5, ST_BAD_ALGO = 3'd6, ST_BAD_LENGTH = 3'd7
   } status_type;

   localparam logic [1:0] CSR_MAGIC = 2'd0;
   localparam logic [1:0] CSR_VERSION = 2'd1;
   localparam logic [1:0] CSR_ALGO = 2'd2;
   localparam logic [1:0] CSR_MAXLEN = 2'd3;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_ADDR_W = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_word_type;

   typedef struct packed {
      logic [3:0]  section;
      logic [7:0]  data_byte;
      logic [7:0]  group_number;
      logic [7:0]  member_number;
      logic        word_valid;
      logic [31:0] word_value;
      logic        finished;
      logic [2:0]  status;
   } out_word_type;
endpackage

// ----- hw/rtl/bcp_stream_if.sv -----
// valid/ready stream interfaces for the parser
`timescale 1ns / 1ps
interface bcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface bcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  section;
   logic [7:0]  data_byte;
   logic [7:0]  group_number;
   logic [7:0]  member_number;
   logic        word_valid;
   logic [31:0] word_value;
   logic        finished;
   logic [2:0]  status;
   modport source (output valid, output section, output data_byte, output group_number,
      output member_number, output word_valid, output word_value, output finished,
      output status, input ready);
   modport sink (input valid, input section, input data_byte, input group_number,
      input member_number, input word_valid, input word_value, input finished,
      input status, output ready);
endinterface

// ----- hw/rtl/backup_container_parser.sv -----
// backup container parser
//
// req channel carries the container one byte per word, last_byte on the final one.
// rsp channel returns one word per byte: section, indices, completed child word or
// ciphertext length, and the latched status; the word for the last byte carries the
// final verdict and finished set, after which parsing restarts for a new container.
// csr port writes magic, version, algorithm and maximum length; write only while idle.
// bytes enter a two-entry queue and the parse engine takes one per cycle while rsp is
// not stalled; a byte is written into the queue, then parsed into the output register.
// sustained throughput is one byte per cycle while rsp is ready, set by the parse step.
// a stalled rsp holds its word in the output register; the queue fills with up to two
// bytes before req ready drops.
// reset is synchronous: queue emptied, parse state cleared, registers to defaults.
`timescale 1ns / 1ps
`include "backup_container_parser_defines.svh"
module backup_container_parser #(
   parameter int SECRET_BYTES = 32,
   parameter int NONCE_BYTES = 12
) (
   input logic clock,
   input logic reset,
   bcp_req_if.sink req,
   bcp_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [bcp_pkg::CSR_ADDR_W-1:0] csr_index,
   input logic [bcp_pkg::CSR_DATA_W-1:0] csr_write_data
);
   logic [47:0] magic_ff;
   logic [7:0] version_ff, algo_ff;
   logic [25:0] maxlen_ff;
   bcp_pkg::in_word_type push_word, q_word;
   bcp_pkg::out_word_type o_word;
   logic q_not_full, q_not_empty, q_pop, o_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0; version_ff <= 8'd1; algo_ff <= 8'd1; maxlen_ff <= 26'd33554432;
      end else if (csr_write_enable) begin
         case (csr_index)
            bcp_pkg::CSR_MAGIC: magic_ff <= csr_write_data;
            bcp_pkg::CSR_VERSION: version_ff <= csr_write_data[7:0];
            bcp_pkg::CSR_ALGO: algo_ff <= csr_write_data[7:0];
            bcp_pkg::CSR_MAXLEN: maxlen_ff <= csr_write_data[25:0];
            default: ;
         endcase
      end
   end

   assign push_word.data_byte = req.byte_in;
   assign push_word.last_byte = req.last_byte;
   assign req.ready = q_not_full;

   bcp_queue u_queue (
      .clock, .reset, .push(req.valid && q_not_full), .push_word, .not_full(q_not_full),
      .pop(q_pop), .not_empty(q_not_empty), .pop_word(q_word)
   );

   bcp_engine #(.SECRET_BYTES(SECRET_BYTES), .NONCE_BYTES(NONCE_BYTES)) u_engine (
      .clock, .reset, .magic_word(magic_ff), .expected_version(version_ff),
      .algorithm_id(algo_ff), .max_payload_length(maxlen_ff), .in_valid(q_not_empty),
      .in_word(q_word), .in_pop(q_pop), .out_valid(o_valid), .out_word(o_word),
      .out_ready(rsp.ready)
   );

   assign rsp.valid = o_valid;
   assign rsp.section = o_word.section;
   assign rsp.data_byte = o_word.data_byte;
   assign rsp.group_number = o_word.group_number;
   assign rsp.member_number = o_word.member_number;
   assign rsp.word_valid = o_word.word_valid;
   assign rsp.word_value = o_word.word_value;
   assign rsp.finished = o_word.finished;
   assign rsp.status = o_word.status;

   `BCP_ASSERT_IMP(a_pop_needs_data, clock, reset, q_pop, q_not_empty, "pop from empty queue")
   `BCP_ASSERT_NXT(a_pop_gives_rsp, clock, reset, q_pop, rsp.valid, "pop without response")
   `BCP_ASSERT_IMP(a_word_value_zero, clock, reset, rsp.valid && !rsp.word_valid,
      rsp.word_value == 32'd0, "word value without word")
endmodule

// ----- hw/rtl/bcp_queue.sv -----
// two-entry queue between the byte front end and the parse engine
`timescale 1ns / 1ps
module bcp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bcp_pkg::in_word_type push_word,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output bcp_pkg::in_word_type pop_word
);
   bcp_pkg::in_word_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign not_full = (cnt_ff != 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ----- hw/rtl/bcp_engine.sv -----
// parse engine: walks the container sections and builds each result word
`timescale 1ns / 1ps
module bcp_engine #(
   parameter int SECRET_BYTES = 32,
   parameter int NONCE_BYTES = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [47:0]           magic_word,
   input  logic [7:0]            expected_version,
   input  logic [7:0]            algorithm_id,
   input  logic [25:0]           max_payload_length,
   input  logic                  in_valid,
   input  bcp_pkg::in_word_type  in_word,
   output logic                  in_pop,
   output logic                  out_valid,
   output bcp_pkg::out_word_type out_word,
   input  logic                  out_ready
);
   localparam logic [4:0] MIN_TOTAL = 5'(6 + 1 + 1 + 1 + 1 + NONCE_BYTES + 1);
   localparam logic [5:0] SECRET_LAST = 6'(SECRET_BYTES - 1);
   localparam logic [5:0] NONCE_LAST = 6'(NONCE_BYTES - 1);

   bcp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  total_ff, total_in;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  gleft_ff, gleft_in, gcnt_ff, gcnt_in, mleft_ff, mleft_in, mcnt_ff, mcnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  lleft_ff, lleft_in;
   logic [25:0] cleft_ff, cleft_in;
   bcp_pkg::status_type err_ff, err_in;
   logic out_valid_ff;
   bcp_pkg::out_word_type out_ff, res;
   logic go;

   assign out_valid = out_valid_ff;
   assign out_word = out_ff;
   assign go = in_valid && (!out_valid_ff || out_ready);
   assign in_pop = go;

   always_comb begin
      logic [7:0] b;
      logic [63:0] lacc;
      logic [63:0] floor_v;
      logic done;
      logic [63:0] len;
      b = in_word.data_byte;
      phase_in = phase_ff; total_in = total_ff; pos_in = pos_ff;
      gleft_in = gleft_ff; gcnt_in = gcnt_ff; mleft_in = mleft_ff; mcnt_in = mcnt_ff;
      acc_in = acc_ff; lleft_in = lleft_ff; cleft_in = cleft_ff; err_in = err_ff;
      res = '0;
      res.section = phase_ff;
      res.data_byte = b;
      done = 1'b0; len = '0; lacc = '0; floor_v = '0;
      case (phase_ff)
         bcp_pkg::SEC_MAGIC: begin
            res.member_number = {2'b0, pos_ff};
            if (pos_ff > 6'd5 || b != magic_word[8*(5-pos_ff[2:0]) +: 8]) begin
               err_in = bcp_pkg::ST_BAD_MAGIC; phase_in = bcp_pkg::SEC_IGNORED;
            end else if (pos_ff == 6'd5) begin
               pos_in = '0; phase_in = bcp_pkg::SEC_VERSION;
            end else pos_in = pos_ff + 6'd1;
         end
         bcp_pkg::SEC_VERSION: begin
            if (b != expected_version) begin
               err_in = bcp_pkg::ST_BAD_VERSION; phase_in = bcp_pkg::SEC_IGNORED;
            end else phase_in = bcp_pkg::SEC_PATH_COUNT;
         end
         bcp_pkg::SEC_PATH_COUNT: begin
            gleft_in = b; gcnt_in = '0;
            phase_in = (b != 8'd0) ? bcp_pkg::SEC_CHILD_COUNT : bcp_pkg::SEC_SECRET_COUNT;
         end
         bcp_pkg::SEC_CHILD_COUNT: begin
            res.group_number = gcnt_ff;
            if (b == 8'd0) begin
               err_in = bcp_pkg::ST_ZERO_CHILD; phase_in = bcp_pkg::SEC_IGNORED;
            end else begin
               mleft_in = b; mcnt_in = '0; pos_in = '0; acc_in = '0;
               phase_in = bcp_pkg::SEC_CHILD_BYTE;
            end
         end
         bcp_pkg::SEC_CHILD_BYTE: begin
            res.group_number = gcnt_ff;
            res.member_number = mcnt_ff;
            acc_in = {32'd0, acc_ff[23:0], b};
            if (pos_ff >= 6'd3) begin
               res.word_valid = 1'b1;
               res.word_value = acc_in[31:0];
               pos_in = '0; acc_in = '0;
               mcnt_in = mcnt_ff + 8'd1;
               mleft_in = mleft_ff - 8'd1;
               if (mleft_ff == 8'd1) begin
                  gcnt_in = gcnt_ff + 8'd1;
                  gleft_in = gleft_ff - 8'd1;
                  phase_in = (gleft_ff != 8'd1) ? bcp_pkg::SEC_CHILD_COUNT
                                                : bcp_pkg::SEC_SECRET_COUNT;
               end
            end else pos_in = pos_ff + 6'd1;
         end
         bcp_pkg::SEC_SECRET_COUNT: begin
            if (b == 8'd0) begin
               err_in = bcp_pkg::ST_ZERO_SECRET; phase_in = bcp_pkg::SEC_IGNORED;
            end else begin
               gleft_in = b; gcnt_in = '0; pos_in = '0; phase_in = bcp_pkg::SEC_SECRET_BYTE;
            end
         end
         bcp_pkg::SEC_SECRET_BYTE: begin
            res.group_number = gcnt_ff;
            res.member_number = {2'b0, pos_ff};
            if (pos_ff >= SECRET_LAST) begin
               pos_in = '0;
               gcnt_in = gcnt_ff + 8'd1;
               gleft_in = gleft_ff - 8'd1;
               if (gleft_ff == 8'd1) phase_in = bcp_pkg::SEC_ALGORITHM;
            end else pos_in = pos_ff + 6'd1;
         end
         bcp_pkg::SEC_ALGORITHM: begin
            if (b != algorithm_id) begin
               err_in = bcp_pkg::ST_BAD_ALGO; phase_in = bcp_pkg::SEC_IGNORED;
            end else begin
               pos_in = '0; phase_in = bcp_pkg::SEC_NONCE;
            end
         end
         bcp_pkg::SEC_NONCE: begin
            res.member_number = {2'b0, pos_ff};
            if (pos_ff >= NONCE_LAST) begin
               pos_in = '0; phase_in = bcp_pkg::SEC_LENGTH;
            end else pos_in = pos_ff + 6'd1;
         end
         bcp_pkg::SEC_LENGTH: begin
            res.member_number = {2'b0, pos_ff};
            if (pos_ff == 6'd0) begin
               if (b < 8'd253) begin
                  done = 1'b1; len = {56'd0, b};
               end else begin
                  lleft_in = (b == 8'd253) ? 4'd2 : (b == 8'd254) ? 4'd4 : 4'd8;
                  acc_in = '0; pos_in = 6'd1;
               end
            end else begin
               lacc = acc_ff | ({56'd0, b} << {pos_ff[2:0] - 3'd1, 3'b000});
               acc_in = lacc;
               pos_in = pos_ff + 6'd1;
               lleft_in = lleft_ff - 4'd1;
               if (lleft_ff == 4'd1) begin
                  floor_v = (pos_in == 6'd3) ? 64'd253
                          : (pos_in == 6'd5) ? 64'h10000 : 64'h1_0000_0000;
                  len = lacc;
                  if (lacc < floor_v || lacc > {38'd0, max_payload_length}) begin
                     err_in = bcp_pkg::ST_BAD_LENGTH; phase_in = bcp_pkg::SEC_IGNORED;
                  end else done = 1'b1;
               end
            end
            if (done) begin
               res.word_valid = 1'b1;
               res.word_value = len[31:0];
               cleft_in = len[25:0];
               pos_in = '0;
               phase_in = (len != 64'd0) ? bcp_pkg::SEC_CIPHER : bcp_pkg::SEC_IGNORED;
            end
         end
         bcp_pkg::SEC_CIPHER: begin
            cleft_in = cleft_ff - 26'd1;
            if (cleft_ff == 26'd1) phase_in = bcp_pkg::SEC_IGNORED;
         end
         default: res.section = bcp_pkg::SEC_IGNORED;
      endcase
      if (total_ff < MIN_TOTAL) total_in = total_ff + 5'd1;
      if (in_word.last_byte) begin
         if (total_in < MIN_TOTAL) err_in = bcp_pkg::ST_TRUNCATED;
         else if (err_in == bcp_pkg::ST_OK && phase_in != bcp_pkg::SEC_IGNORED)
            err_in = (phase_in == bcp_pkg::SEC_LENGTH) ? bcp_pkg::ST_BAD_LENGTH
                                                       : bcp_pkg::ST_TRUNCATED;
      end
      res.finished = in_word.last_byte;
      res.status = err_in;
   end

   always_ff @(posedge clock) begin
      if (go) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (go) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (go && in_word.last_byte)) begin
         phase_ff <= bcp_pkg::SEC_MAGIC; total_ff <= '0; pos_ff <= '0;
         gleft_ff <= '0; gcnt_ff <= '0; mleft_ff <= '0; mcnt_ff <= '0;
         acc_ff <= '0; lleft_ff <= '0; cleft_ff <= '0; err_ff <= bcp_pkg::ST_OK;
      end else if (go) begin
         phase_ff <= phase_in; total_ff <= total_in; pos_ff <= pos_in;
         gleft_ff <= gleft_in; gcnt_ff <= gcnt_in; mleft_ff <= mleft_in; mcnt_ff <= mcnt_in;
         acc_ff <= acc_in; lleft_ff <= lleft_in; cleft_ff <= cleft_in; err_ff <= err_in;
      end
   end
endmodule
